@@ hw/rtl/plsh_pkg.sv @@
// Shared widths, constants, register codes and cell payload types for point light shading.
`timescale 1ns / 1ps

package plsh_pkg;

  // fixed point
  localparam int FRAC_BITS = 16;

  // register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_LIGHT_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIGHT_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIGHT_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_COLOR_R = 3'd3;
  localparam logic [IDX_W-1:0] REG_COLOR_G = 3'd4;
  localparam logic [IDX_W-1:0] REG_COLOR_B = 3'd5;
  localparam logic [IDX_W-1:0] REG_POWER   = 3'd6;

  // operand widths
  localparam int POS_W  = 32;
  localparam int DIFF_W = POS_W + 1;          // hit - light, and its magnitude
  localparam int SQ_W   = 2 * POS_W + 1;      // one squared axis
  localparam int D_W    = 2 * DIFF_W;         // sum of three squares
  localparam int COL_W  = 17;
  localparam int PWR_W  = 32;
  localparam int CP_W   = COL_W + PWR_W;      // color * power

  localparam logic [COL_W-1:0] COLOR_ONE = 17'h10000;
  localparam logic [PWR_W-1:0] POWER_ONE = 32'd1 << FRAC_BITS;

  // 4*pi in Q16
  localparam int FOUR_PI_W = 20;
  localparam logic [FOUR_PI_W-1:0] FOUR_PI_Q = 20'd823550;
  localparam int PP_W  = DIFF_W + FOUR_PI_W;  // partial product of 4pi * half of D
  localparam int DEN_W = 86;                  // 4pi * D, D <= 3 * 2^64

  // intensity divider
  localparam int NUM_SH  = 2 * FRAC_BITS + 1;
  localparam int NUM_W   = CP_W + NUM_SH;
  localparam int T_W     = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
  localparam int RECV_W  = 31;
  localparam int RV_E_W  = DEN_W + 1;
  localparam int RV_X_W  = RV_E_W + 1;
  localparam int RV_R0_W = T_W - RECV_W;
  localparam logic [RECV_W-1:0] SAT31 = 31'h7FFF_FFFF;

  // square root
  localparam int ROOT_W    = 34;
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int SQ_X_W    = SQ_REM_W + 2;
  localparam int SQ_BITS_W = 2 * ROOT_W;
  localparam int R_W       = ROOT_W + 1;      // rounded root

  // direction divider
  localparam int DIR_Q_W = 17;
  localparam int DIR_E_W = R_W + 1;
  localparam int DV_X_W  = DIR_E_W + 1;
  localparam int DIR_W   = 18;
  localparam logic signed [DIR_W-1:0] DIR_ONE = 18'sd65536;

  // alignment of the parallel paths
  localparam int CTL_DLY = ROOT_W + 2 + DIR_Q_W;
  localparam int DLY_D   = CTL_DLY - 4 - RECV_W;
  localparam int A_DLY   = ROOT_W + 3;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [ROOT_W-1:0]    root;
    logic [SQ_BITS_W-1:0] bits;
  } sq_t;

  typedef struct packed {
    logic [DIR_E_W-1:0] rem;
    logic [DIR_E_W-1:0] den;
    logic [DIR_Q_W-1:0] low;
    logic [DIR_Q_W-1:0] quo;
  } dv_t;

  typedef struct packed {
    logic [RV_E_W-1:0] rem;
    logic [RV_E_W-1:0] den;
    logic [RECV_W-1:0] low;
    logic [RECV_W-1:0] quo;
  } rv_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
    logic       zero;
  } ctl_t;

endpackage

@@ hw/rtl/point_light_shading.sv @@
// Top level of point light shading: config registers, front end, cell chains, output stage.
`timescale 1ns / 1ps

//  channel   handshake                        payload
//  in        in_valid / in_ready              in_hit_x, in_hit_y, in_hit_z
//  out       out_valid / out_ready            out_recv_*, out_dist_res, out_dir_*, out_degenerate
//  cfg       psel, penable, pwrite / pready   paddr, pwdata -> prdata
//
//  One beat in and one beat out per cycle, sustained while out_ready stays high. A result
//  reaches the output register through the 34-cell square root chain followed by the
//  17-cell direction divider; the intensity divider (31 cells) runs beside them.
//  Reset (rst_n low at a clock edge) clears the valid bits and loads the register defaults.
//  A stall on out_ready freezes every stage at once; in_ready drops only while a result
//  waits in the output register and out_ready is low.

module point_light_shading (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [plsh_pkg::POS_W-1:0]  in_hit_x,
  input  logic signed [plsh_pkg::POS_W-1:0]  in_hit_y,
  input  logic signed [plsh_pkg::POS_W-1:0]  in_hit_z,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [plsh_pkg::RECV_W-1:0]        out_recv_red,
  output logic [plsh_pkg::RECV_W-1:0]        out_recv_green,
  output logic [plsh_pkg::RECV_W-1:0]        out_recv_blue,
  output logic [plsh_pkg::RECV_W-1:0]        out_dist_res,
  output logic signed [plsh_pkg::DIR_W-1:0]  out_dir_x,
  output logic signed [plsh_pkg::DIR_W-1:0]  out_dir_y,
  output logic signed [plsh_pkg::DIR_W-1:0]  out_dir_z,
  output logic                               out_degenerate,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [plsh_pkg::ADDR_W-1:0]        paddr,
  input  logic [plsh_pkg::DATA_W-1:0]        pwdata,
  output logic [plsh_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------------------
  logic [plsh_pkg::POS_W-1:0] light_r [0:2];
  logic [plsh_pkg::COL_W-1:0] color_r [0:2];
  logic [plsh_pkg::PWR_W-1:0] power_r;
  logic                       cfg_wr;
  logic [plsh_pkg::IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[plsh_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= '0;
      light_r[1] <= '0;
      light_r[2] <= '0;
      color_r[0] <= plsh_pkg::COLOR_ONE;
      color_r[1] <= plsh_pkg::COLOR_ONE;
      color_r[2] <= plsh_pkg::COLOR_ONE;
      power_r    <= plsh_pkg::POWER_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        plsh_pkg::REG_LIGHT_X: light_r[0] <= pwdata;
        plsh_pkg::REG_LIGHT_Y: light_r[1] <= pwdata;
        plsh_pkg::REG_LIGHT_Z: light_r[2] <= pwdata;
        plsh_pkg::REG_COLOR_R: color_r[0] <= pwdata[plsh_pkg::COL_W-1:0];
        plsh_pkg::REG_COLOR_G: color_r[1] <= pwdata[plsh_pkg::COL_W-1:0];
        plsh_pkg::REG_COLOR_B: color_r[2] <= pwdata[plsh_pkg::COL_W-1:0];
        plsh_pkg::REG_POWER:   power_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      plsh_pkg::REG_LIGHT_X: prdata = light_r[0];
      plsh_pkg::REG_LIGHT_Y: prdata = light_r[1];
      plsh_pkg::REG_LIGHT_Z: prdata = light_r[2];
      plsh_pkg::REG_COLOR_R: prdata = plsh_pkg::DATA_W'(color_r[0]);
      plsh_pkg::REG_COLOR_G: prdata = plsh_pkg::DATA_W'(color_r[1]);
      plsh_pkg::REG_COLOR_B: prdata = plsh_pkg::DATA_W'(color_r[2]);
      plsh_pkg::REG_POWER:   prdata = power_r;
      default:               prdata = '0;
    endcase
  end

  // color * power; user keeps config stable while beats are in flight; not enforced here
  logic [plsh_pkg::CP_W-1:0] cp_r [0:2];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      cp_r[c] <= plsh_pkg::CP_W'(color_r[c]) * plsh_pkg::CP_W'(power_r);
    end
  end

  // ---------------------------------------------------------------------------------------
  // global advance: the whole pipe moves unless a result is stuck at the output
  // ---------------------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------------------
  // front end: difference, squares, sum
  // ---------------------------------------------------------------------------------------
  logic [plsh_pkg::POS_W-1:0]    hit_w  [0:2];
  logic [plsh_pkg::DIFF_W-1:0]   diff_w [0:2];
  logic [plsh_pkg::DIFF_W-1:0]   mag_w  [0:2];
  logic [2*plsh_pkg::DIFF_W-1:0] prod_w [0:2];

  logic [plsh_pkg::DIFF_W-1:0] s1_a_r  [0:2];
  logic [plsh_pkg::SQ_W-1:0]   s2_sq_r [0:2];
  logic [plsh_pkg::D_W-1:0]    s3_d_r;
  plsh_pkg::ctl_t              s1_ctl_r, s2_ctl_r, s3_ctl_r;

  assign hit_w[0] = in_hit_x;
  assign hit_w[1] = in_hit_y;
  assign hit_w[2] = in_hit_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_w[i] = {hit_w[i][plsh_pkg::POS_W-1], hit_w[i]}
                - {light_r[i][plsh_pkg::POS_W-1], light_r[i]};
      mag_w[i]  = diff_w[i][plsh_pkg::DIFF_W-1] ? (~diff_w[i] + 1'b1) : diff_w[i];
      prod_w[i] = s1_a_r[i] * s1_a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_a_r[i]  <= mag_w[i];
        s2_sq_r[i] <= prod_w[i][plsh_pkg::SQ_W-1:0];
      end
      s3_d_r <= plsh_pkg::D_W'(s2_sq_r[0]) + plsh_pkg::D_W'(s2_sq_r[1])
              + plsh_pkg::D_W'(s2_sq_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.valid <= in_valid;
      s1_ctl_r.neg   <= {diff_w[2][plsh_pkg::DIFF_W-1], diff_w[1][plsh_pkg::DIFF_W-1],
                         diff_w[0][plsh_pkg::DIFF_W-1]};
      s1_ctl_r.zero  <= 1'b0;
      s2_ctl_r.valid <= s1_ctl_r.valid;
      s2_ctl_r.neg   <= s1_ctl_r.neg;
      s2_ctl_r.zero  <= (s1_a_r[0] == '0) && (s1_a_r[1] == '0) && (s1_a_r[2] == '0);
      s3_ctl_r       <= s2_ctl_r;
    end
  end

  // control and magnitude shift lines that ride beside the chains
  plsh_pkg::ctl_t              ctl_sl [0:plsh_pkg::CTL_DLY-1];
  logic [plsh_pkg::DIFF_W-1:0] a_sl   [0:plsh_pkg::A_DLY-1][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < plsh_pkg::CTL_DLY; j++) begin
        ctl_sl[j] <= '0;
      end
    end else if (en) begin
      ctl_sl[0] <= s3_ctl_r;
      for (int j = 1; j < plsh_pkg::CTL_DLY; j++) begin
        ctl_sl[j] <= ctl_sl[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_sl[0][i] <= s1_a_r[i];
        for (int j = 1; j < plsh_pkg::A_DLY; j++) begin
          a_sl[j][i] <= a_sl[j-1][i];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // distance: square root chain, then round to nearest
  // ---------------------------------------------------------------------------------------
  plsh_pkg::sq_t           sq_sig [0:plsh_pkg::ROOT_W];
  logic [plsh_pkg::R_W-1:0] rnd_r;

  assign sq_sig[0].rem  = '0;
  assign sq_sig[0].root = '0;
  assign sq_sig[0].bits = plsh_pkg::SQ_BITS_W'(s3_d_r);

  for (genvar j = 0; j < plsh_pkg::ROOT_W; j++) begin : g_sqrt
    plsh_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d_i (sq_sig[j]),
      .d_o (sq_sig[j+1])
    );
  end

  // remainder D - f^2 above f means the root rounds up
  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r <= plsh_pkg::R_W'(sq_sig[plsh_pkg::ROOT_W].root)
             + plsh_pkg::R_W'(sq_sig[plsh_pkg::ROOT_W].rem
                              > plsh_pkg::SQ_REM_W'(sq_sig[plsh_pkg::ROOT_W].root));
    end
  end

  // ---------------------------------------------------------------------------------------
  // direction: (|d| * 2^17 + r) / (2r), one lane per axis
  // ---------------------------------------------------------------------------------------
  plsh_pkg::dv_t dv0_r  [0:2];
  plsh_pkg::dv_t dv_sig [0:2][0:plsh_pkg::DIR_Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv0_r[i].rem <= plsh_pkg::DIR_E_W'(a_sl[plsh_pkg::A_DLY-1][i])
                      + plsh_pkg::DIR_E_W'(rnd_r[plsh_pkg::R_W-1:plsh_pkg::DIR_Q_W]);
        dv0_r[i].den <= {rnd_r, 1'b0};
        dv0_r[i].low <= rnd_r[plsh_pkg::DIR_Q_W-1:0];
        dv0_r[i].quo <= '0;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dir_lane
    assign dv_sig[i][0] = dv0_r[i];
    for (genvar j = 0; j < plsh_pkg::DIR_Q_W; j++) begin : g_dir
      plsh_dir_cell u_cell (
        .clk (clk),
        .en  (en),
        .d_i (dv_sig[i][j]),
        .d_o (dv_sig[i][j+1])
      );
    end
  end

  // ---------------------------------------------------------------------------------------
  // received intensity: round(cp * 2^2F / (4pi * D)), saturated
  // ---------------------------------------------------------------------------------------
  logic [plsh_pkg::D_W-1:0]     d_sl [0:plsh_pkg::DLY_D-1];
  logic [plsh_pkg::PP_W-1:0]    plo_r, phi_r;
  logic [plsh_pkg::DEN_W-1:0]   den_r;
  logic [plsh_pkg::T_W-1:0]     t_r [0:2];
  logic [plsh_pkg::RV_E_W-1:0]  e2_r;
  logic [plsh_pkg::RV_R0_W-1:0] rv_r0_w [0:2];
  logic                         rv_sat_w [0:2];
  plsh_pkg::rv_t                rv0_r  [0:2];
  plsh_pkg::rv_t                rv_sig [0:2][0:plsh_pkg::RECV_W];

  always_ff @(posedge clk) begin
    if (en) begin
      d_sl[0] <= s3_d_r;
      for (int j = 1; j < plsh_pkg::DLY_D; j++) begin
        d_sl[j] <= d_sl[j-1];
      end
      plo_r <= plsh_pkg::PP_W'(d_sl[plsh_pkg::DLY_D-1][plsh_pkg::DIFF_W-1:0])
             * plsh_pkg::PP_W'(plsh_pkg::FOUR_PI_Q);
      phi_r <= plsh_pkg::PP_W'(d_sl[plsh_pkg::DLY_D-1][plsh_pkg::D_W-1:plsh_pkg::DIFF_W])
             * plsh_pkg::PP_W'(plsh_pkg::FOUR_PI_Q);
      den_r <= plsh_pkg::DEN_W'(plo_r)
             + plsh_pkg::DEN_W'({phi_r, {plsh_pkg::DIFF_W{1'b0}}});
      e2_r  <= {den_r, 1'b0};
      for (int c = 0; c < 3; c++) begin
        // 2*num + den folds the half-up rounding into the dividend
        t_r[c] <= plsh_pkg::T_W'({cp_r[c], {plsh_pkg::NUM_SH{1'b0}}})
                + plsh_pkg::T_W'(den_r);
      end
    end
  end

  // quotient of 2^31 or more saturates: zero divisor makes the chain emit all ones
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rv_r0_w[c]  = t_r[c][plsh_pkg::T_W-1:plsh_pkg::RECV_W];
      rv_sat_w[c] = (plsh_pkg::RV_E_W'(rv_r0_w[c]) >= e2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rv0_r[c].rem <= rv_sat_w[c] ? '0 : plsh_pkg::RV_E_W'(rv_r0_w[c]);
        rv0_r[c].den <= rv_sat_w[c] ? '0 : e2_r;
        rv0_r[c].low <= t_r[c][plsh_pkg::RECV_W-1:0];
        rv0_r[c].quo <= '0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_recv_lane
    assign rv_sig[c][0] = rv0_r[c];
    for (genvar j = 0; j < plsh_pkg::RECV_W; j++) begin : g_recv
      plsh_recv_cell u_cell (
        .clk (clk),
        .en  (en),
        .d_i (rv_sig[c][j]),
        .d_o (rv_sig[c][j+1])
      );
    end
  end

  // ---------------------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------------------
  plsh_pkg::ctl_t              tail;
  logic [plsh_pkg::R_W-1:0]    r_tail;
  logic [plsh_pkg::DIR_W-1:0]  dir_mag [0:2];
  logic [plsh_pkg::DIR_W-1:0]  dir_w   [0:2];
  logic [plsh_pkg::RECV_W-1:0] dist_w;

  always_comb begin
    tail   = ctl_sl[plsh_pkg::CTL_DLY-1];
    r_tail = dv_sig[0][plsh_pkg::DIR_Q_W].den[plsh_pkg::DIR_E_W-1:1];
    dist_w = (r_tail > plsh_pkg::R_W'(plsh_pkg::SAT31)) ? plsh_pkg::SAT31
                                                        : r_tail[plsh_pkg::RECV_W-1:0];
    for (int i = 0; i < 3; i++) begin
      dir_mag[i] = plsh_pkg::DIR_W'(dv_sig[i][plsh_pkg::DIR_Q_W].quo);
      dir_w[i]   = tail.neg[i] ? (~dir_mag[i] + 1'b1) : dir_mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_degenerate <= tail.zero;
      out_recv_red   <= tail.zero ? '0 : rv_sig[0][plsh_pkg::RECV_W].quo;
      out_recv_green <= tail.zero ? '0 : rv_sig[1][plsh_pkg::RECV_W].quo;
      out_recv_blue  <= tail.zero ? '0 : rv_sig[2][plsh_pkg::RECV_W].quo;
      out_dist_res   <= tail.zero ? '0 : dist_w;
      out_dir_x      <= tail.zero ? '0 : dir_w[0];
      out_dir_y      <= tail.zero ? '0 : dir_w[1];
      out_dir_z      <= tail.zero ? '0 : dir_w[2];
    end
  end

`ifndef SYNTH
  a_take_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_ctl_r.valid)
    else $error("accepted beat did not enter the first stage");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_dist_res == '0 && out_recv_red == '0
      && out_recv_green == '0 && out_recv_blue == '0 && out_dir_x == '0
      && out_dir_y == '0 && out_dir_z == '0)
    else $error("degenerate result carries nonzero fields");

  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_dist_res != '0)
    else $error("zero distance without degenerate flag");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_x <= plsh_pkg::DIR_ONE && out_dir_x >= -plsh_pkg::DIR_ONE
      && out_dir_y <= plsh_pkg::DIR_ONE && out_dir_y >= -plsh_pkg::DIR_ONE
      && out_dir_z <= plsh_pkg::DIR_ONE && out_dir_z >= -plsh_pkg::DIR_ONE)
    else $error("direction component beyond unit length");
`endif

endmodule

@@ hw/rtl/plsh_sqrt_cell.sv @@
// One digit of the restoring square root: two radicand bits in, one root bit out.
`timescale 1ns / 1ps

module plsh_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  plsh_pkg::sq_t  d_i,
  output plsh_pkg::sq_t  d_o
);

  logic [plsh_pkg::SQ_X_W-1:0] x;
  logic [plsh_pkg::SQ_X_W-1:0] trial;
  logic                        ge;
  plsh_pkg::sq_t               d_nxt;
  plsh_pkg::sq_t               d_r;

  always_comb begin
    x          = {d_i.rem, d_i.bits[plsh_pkg::SQ_BITS_W-1 -: 2]};
    trial      = plsh_pkg::SQ_X_W'({d_i.root, 2'b01});
    ge         = (x >= trial);
    d_nxt.rem  = ge ? plsh_pkg::SQ_REM_W'(x - trial) : plsh_pkg::SQ_REM_W'(x);
    d_nxt.root = {d_i.root[plsh_pkg::ROOT_W-2:0], ge};
    d_nxt.bits = {d_i.bits[plsh_pkg::SQ_BITS_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

@@ hw/rtl/plsh_dir_cell.sv @@
// One quotient bit of the direction divider (shift-in restoring division).
`timescale 1ns / 1ps

module plsh_dir_cell (
  input  logic           clk,
  input  logic           en,
  input  plsh_pkg::dv_t  d_i,
  output plsh_pkg::dv_t  d_o
);

  logic [plsh_pkg::DV_X_W-1:0] x;
  logic [plsh_pkg::DV_X_W-1:0] den_x;
  logic                        ge;
  plsh_pkg::dv_t               d_nxt;
  plsh_pkg::dv_t               d_r;

  always_comb begin
    x         = {d_i.rem, d_i.low[plsh_pkg::DIR_Q_W-1]};
    den_x     = plsh_pkg::DV_X_W'(d_i.den);
    ge        = (x >= den_x);
    d_nxt.rem = ge ? plsh_pkg::DIR_E_W'(x - den_x) : plsh_pkg::DIR_E_W'(x);
    d_nxt.den = d_i.den;
    d_nxt.low = {d_i.low[plsh_pkg::DIR_Q_W-2:0], 1'b0};
    d_nxt.quo = {d_i.quo[plsh_pkg::DIR_Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

@@ hw/rtl/plsh_recv_cell.sv @@
// One quotient bit of the received intensity divider (shift-in restoring division).
`timescale 1ns / 1ps

module plsh_recv_cell (
  input  logic           clk,
  input  logic           en,
  input  plsh_pkg::rv_t  d_i,
  output plsh_pkg::rv_t  d_o
);

  logic [plsh_pkg::RV_X_W-1:0] x;
  logic [plsh_pkg::RV_X_W-1:0] den_x;
  logic                        ge;
  plsh_pkg::rv_t               d_nxt;
  plsh_pkg::rv_t               d_r;

  // a zero divisor forces all-ones, which is how saturation rides the chain
  always_comb begin
    x         = {d_i.rem, d_i.low[plsh_pkg::RECV_W-1]};
    den_x     = plsh_pkg::RV_X_W'(d_i.den);
    ge        = (x >= den_x);
    d_nxt.rem = ge ? plsh_pkg::RV_E_W'(x - den_x) : plsh_pkg::RV_E_W'(x);
    d_nxt.den = d_i.den;
    d_nxt.low = {d_i.low[plsh_pkg::RECV_W-2:0], 1'b0};
    d_nxt.quo = {d_i.quo[plsh_pkg::RECV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

@@ tb/sv/point_light_shading_test.sv @@
// Self-checking testbench for point_light_shading: directed table, random hit points, APB setup.
`timescale 1ns / 1ps

module point_light_shading_test;

  localparam logic [plsh_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;  // past the map, write dropped
  localparam int LIMIT      = 600000;              // cycles before we call it hung
  localparam int DRAIN      = 120;                 // exceeds the pipeline latency
  localparam int RAND_ITEMS = 550;
  localparam int PHASES     = 7;

  typedef struct packed {
    logic [plsh_pkg::RECV_W-1:0]       red, green, blue, distance;
    logic signed [plsh_pkg::DIR_W-1:0] dx, dy, dz;
    logic                              degen;
  } shade_t;

  typedef struct {
    logic signed [plsh_pkg::POS_W-1:0] x, y, z;
    bit                                typed;   // expected value written by hand
    shade_t                            want;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic signed [plsh_pkg::POS_W-1:0] in_hit_x, in_hit_y, in_hit_z;
  logic out_valid, out_ready;
  logic [plsh_pkg::RECV_W-1:0] out_recv_red, out_recv_green, out_recv_blue, out_dist_res;
  logic signed [plsh_pkg::DIR_W-1:0] out_dir_x, out_dir_y, out_dir_z;
  logic out_degenerate;
  logic psel, penable, pwrite, pready;
  logic [plsh_pkg::ADDR_W-1:0] paddr;
  logic [plsh_pkg::DATA_W-1:0] pwdata, prdata;

  // shadow copy of the light registers
  logic signed [plsh_pkg::POS_W-1:0] light_pos [3];
  logic [plsh_pkg::COL_W-1:0]        light_col [3];
  logic [plsh_pkg::PWR_W-1:0]        light_pwr;

  shade_t    pending_shades [$];
  stim_row_t directed [$];
  int        err_count;
  int        cycle_count;
  bit        rx_steady;    // when set the sink never stalls

  point_light_shading uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Golden shading math: exact integer arithmetic on 128-bit vectors.
  function automatic shade_t shade_point(logic signed [plsh_pkg::POS_W-1:0] hx, hy, hz);
    logic signed [plsh_pkg::DIFF_W-1:0] d [3];
    logic [plsh_pkg::DIFF_W-1:0] mag [3];
    logic [127:0] dsq, root, cand, q, den, num, t;
    logic signed [plsh_pkg::POS_W-1:0] hit [3];
    shade_t s;
    s = '0;
    hit[0] = hx; hit[1] = hy; hit[2] = hz;
    dsq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i]   = {hit[i][plsh_pkg::POS_W-1], hit[i]}
             - {light_pos[i][plsh_pkg::POS_W-1], light_pos[i]};
      mag[i] = d[i][plsh_pkg::DIFF_W-1] ? -d[i] : d[i];
      dsq    = dsq + 128'(mag[i]) * 128'(mag[i]);
    end
    if (dsq == 0) begin
      // hit point sits on the light
      s.degen = 1'b1;
      return s;
    end
    root = '0;
    for (int b = plsh_pkg::ROOT_W; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= dsq) root = cand;
    end
    if (dsq - root * root > root) root = root + 1;  // round to nearest
    s.distance = (root > 128'(plsh_pkg::SAT31)) ? plsh_pkg::SAT31
                                                : root[plsh_pkg::RECV_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q = ((128'(mag[i]) << 17) + root) / (root << 1);
      if (q > 128'd65536) q = 128'd65536;
      q = d[i][plsh_pkg::DIFF_W-1] ? -q : q;
      case (i)
        0: s.dx = q[plsh_pkg::DIR_W-1:0];
        1: s.dy = q[plsh_pkg::DIR_W-1:0];
        default: s.dz = q[plsh_pkg::DIR_W-1:0];
      endcase
    end
    den = dsq * 128'(plsh_pkg::FOUR_PI_Q);
    for (int i = 0; i < 3; i++) begin
      num = (128'(light_col[i]) * 128'(light_pwr)) << (2 * plsh_pkg::FRAC_BITS);
      t   = (num << 1) + den;
      q   = t / (den << 1);
      q   = (q > 128'(plsh_pkg::SAT31)) ? 128'(plsh_pkg::SAT31) : q;
      case (i)
        0: s.red = q[plsh_pkg::RECV_W-1:0];
        1: s.green = q[plsh_pkg::RECV_W-1:0];
        default: s.blue = q[plsh_pkg::RECV_W-1:0];
      endcase
    end
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string field, longint got, longint want);
    err_count++;
    $display("mismatch %s: got %0h want %0h (cycle %0d)", field, got, want, cycle_count);
  endtask

  // APB write: setup cycle, then access; register takes the value at the access edge.
  task automatic reg_write(logic [plsh_pkg::IDX_W-1:0] idx, logic [plsh_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      plsh_pkg::REG_LIGHT_X: light_pos[0] = val;
      plsh_pkg::REG_LIGHT_Y: light_pos[1] = val;
      plsh_pkg::REG_LIGHT_Z: light_pos[2] = val;
      plsh_pkg::REG_COLOR_R: light_col[0] = val[plsh_pkg::COL_W-1:0];
      plsh_pkg::REG_COLOR_G: light_col[1] = val[plsh_pkg::COL_W-1:0];
      plsh_pkg::REG_COLOR_B: light_col[2] = val[plsh_pkg::COL_W-1:0];
      plsh_pkg::REG_POWER:   light_pwr    = val;
      default: ;  // unmapped, ignored by the block too
    endcase
    @(posedge clk);  // bus idle between transfers
  endtask

  // Hold the beat until taken, then queue its expectation.
  task automatic send_hit(stim_row_t row, bit hold_on);
    int gap;
    in_valid <= 1'b1;
    in_hit_x <= row.x;
    in_hit_y <= row.y;
    in_hit_z <= row.z;
    do @(posedge clk); while (!in_ready);
    pending_shades.push_back(row.typed ? row.want : shade_point(row.x, row.y, row.z));
    gap = hold_on ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 32'h8000_0000;
    if (r < 4) return 32'h7FFF_FFFF;
    if (r < 5) return 32'h0;
    return $urandom;
  endfunction

  function automatic logic [plsh_pkg::COL_W-1:0] pick_color();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return plsh_pkg::COLOR_ONE;
    if (r == 2) return '1;       // above 1.0, used as given
    return $urandom_range(0, 131071);
  endfunction

  function automatic stim_row_t random_hit();
    stim_row_t row;
    int mode;
    mode = $urandom_range(0, 99);
    row.typed = 1'b0;
    row.want  = '0;
    if (mode < 55) begin
      // near the light: keeps intensity out of saturation
      row.x = light_pos[0] + $signed($urandom_range(0, 2**21) - 2**20);
      row.y = light_pos[1] + $signed($urandom_range(0, 2**21) - 2**20);
      row.z = light_pos[2] + $signed($urandom_range(0, 2**21) - 2**20);
    end else if (mode < 85) begin
      row.x = $urandom;
      row.y = $urandom;
      row.z = $urandom;
    end else if (mode < 92) begin
      row.x = light_pos[0];
      row.y = light_pos[1];
      row.z = light_pos[2];
    end else begin
      row.x = pick_coord();
      row.y = pick_coord();
      row.z = pick_coord();
    end
    return row;
  endfunction

  task automatic add_row(logic signed [31:0] x, y, z, bit typed, shade_t want);
    stim_row_t row;
    row.x = x; row.y = y; row.z = z;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endtask

  // Sink side: random stalls, sometimes a steady stretch.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: oldest expectation against each accepted beat.
  always @(posedge clk) begin
    shade_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_shades.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        want = pending_shades.pop_front();
        if (out_recv_red   !== want.red)   report("recv_red", out_recv_red, want.red);
        if (out_recv_green !== want.green) report("recv_green", out_recv_green, want.green);
        if (out_recv_blue  !== want.blue)  report("recv_blue", out_recv_blue, want.blue);
        if (out_dist_res   !== want.distance) report("dist_res", out_dist_res, want.distance);
        if (out_dir_x      !== want.dx)    report("dir_x", out_dir_x, want.dx);
        if (out_dir_y      !== want.dy)    report("dir_y", out_dir_y, want.dy);
        if (out_dir_z      !== want.dz)    report("dir_z", out_dir_z, want.dz);
        if (out_degenerate !== want.degen) report("degenerate", out_degenerate, want.degen);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    shade_t w;
    stim_row_t row;
    int burst;
    err_count   = 0;
    cycle_count = 0;
    rx_steady   = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_hit_x <= '0;
    in_hit_y <= '0;
    in_hit_z <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    for (int i = 0; i < 3; i++) begin
      light_pos[i] = '0;
      light_col[i] = plsh_pkg::COLOR_ONE;
    end
    light_pwr = plsh_pkg::POWER_ONE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under reset defaults: light at origin, white, power 1.0.
    w = '0; w.degen = 1'b1;
    add_row(0, 0, 0, 1, w);                         // hit on the light
    w = '0; w.red = 5215; w.green = 5215; w.blue = 5215; w.distance = 65536;
    w.dx = plsh_pkg::DIR_ONE;
    add_row(65536, 0, 0, 1, w);                     // one unit away on x
    w.dx = 0; w.dy = -plsh_pkg::DIR_ONE;
    add_row(0, -65536, 0, 1, w);
    w.dy = 0; w.dz = plsh_pkg::DIR_ONE;
    add_row(0, 0, 65536, 1, w);
    w = '0; w.red = plsh_pkg::SAT31; w.green = plsh_pkg::SAT31; w.blue = plsh_pkg::SAT31;
    w.distance = 1; w.dx = -plsh_pkg::DIR_ONE;
    add_row(-1, 0, 0, 1, w);                        // tiny distance saturates intensity
    w = '0;
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, w);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, w);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, w);
    add_row(3, 4, 0, 0, w);
    add_row(32'h0001_8000, -32'sh0000_C000, 32'h0000_4000, 0, w);
    foreach (directed[i]) send_hit(directed[i], 1'b0);
    wait_idle();

    // Extremes: far corner light, colors off / one / above one, full power.
    reg_write(plsh_pkg::REG_LIGHT_X, 32'h8000_0000);
    reg_write(plsh_pkg::REG_LIGHT_Y, 32'h7FFF_FFFF);
    reg_write(plsh_pkg::REG_LIGHT_Z, 32'h8000_0000);
    reg_write(plsh_pkg::REG_COLOR_R, 32'h0);
    reg_write(plsh_pkg::REG_COLOR_G, 32'h1FFFF);
    reg_write(plsh_pkg::REG_COLOR_B, 32'h10000);
    reg_write(plsh_pkg::REG_POWER, 32'hFFFF_FFFF);
    reg_write(REG_UNUSED, 32'hDEAD_BEEF);           // must not disturb anything
    directed.delete();
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, w);  // longest vector
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, w);  // on the light
    add_row(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 0, w);
    add_row(32'h8010_0000, 32'h7FF0_0000, 32'h8000_8000, 0, w);
    add_row(0, 0, 0, 0, w);
    foreach (directed[i]) send_hit(directed[i], 1'b1);  // back to back
    wait_idle();
    reg_write(plsh_pkg::REG_POWER, 32'h0);
    send_hit(directed[3], 1'b0);
    wait_idle();

    // Random phases, each with its own light.
    for (int p = 0; p < PHASES; p++) begin
      rx_steady = (p == 2);
      if (p == PHASES - 1) begin
        reg_write(plsh_pkg::REG_LIGHT_X, 32'h0);
        reg_write(plsh_pkg::REG_LIGHT_Y, 32'h0);
        reg_write(plsh_pkg::REG_LIGHT_Z, 32'h0);
        reg_write(plsh_pkg::REG_COLOR_R, plsh_pkg::COLOR_ONE);
        reg_write(plsh_pkg::REG_COLOR_G, plsh_pkg::COLOR_ONE);
        reg_write(plsh_pkg::REG_COLOR_B, plsh_pkg::COLOR_ONE);
        reg_write(plsh_pkg::REG_POWER, plsh_pkg::POWER_ONE);
      end else begin
        reg_write(plsh_pkg::REG_LIGHT_X, pick_coord());
        reg_write(plsh_pkg::REG_LIGHT_Y, pick_coord());
        reg_write(plsh_pkg::REG_LIGHT_Z, pick_coord());
        reg_write(plsh_pkg::REG_COLOR_R, pick_color());
        reg_write(plsh_pkg::REG_COLOR_G, pick_color());
        reg_write(plsh_pkg::REG_COLOR_B, pick_color());
        reg_write(plsh_pkg::REG_POWER, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      end
      burst = 0;
      for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
        if (burst == 0 && $urandom_range(0, 15) == 0) burst = $urandom_range(5, 20);
        row = random_hit();
        send_hit(row, (burst > 0) || (p == 2));
        if (burst > 0) burst--;
      end
      wait_idle();   // sender holds off until the pipe is empty
    end

    in_valid <= 1'b0;
    rx_steady = 1'b1;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
